/* src/tmtw_pkg.sv */
// shared types and constants of the text-mode terminal writer
package tmtw_pkg;

  // default geometry and queue depth
  localparam int COLUMNS_DEF     = 80;
  localparam int ROWS_DEF        = 25;
  localparam int QUEUE_DEPTH_DEF = 2;

  // fixed field widths
  localparam int MODE_W = 2;
  localparam int CHAR_W = 8;
  localparam int IDX_W  = 11;
  localparam int POS_W  = 11;

  // special character codes and the reset color
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [CHAR_W-1:0] COLOR_RESET  = 8'h0A;

  // input modes
  typedef enum logic [MODE_W-1:0] {
    MODE_PUT   = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  // classified commands handed from front to back
  typedef enum logic [2:0] {
    OP_PUT,
    OP_NEWLINE,
    OP_BACKSPACE,
    OP_CLEAR,
    OP_READ,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [CHAR_W-1:0] ch;
    logic [IDX_W-1:0]  idx;
  } cmd_t;

  // back end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FILL,
    BK_READ
  } back_state_t;

endpackage

/* src/tmtw_front.sv */
// front end: takes input beats and classifies them into commands
module tmtw_front (
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [tmtw_pkg::MODE_W-1:0] mode,
  input  logic [tmtw_pkg::CHAR_W-1:0] char_code,
  input  logic [tmtw_pkg::IDX_W-1:0]  cell_index,
  output logic                       push_valid,
  input  logic                       push_ready,
  output tmtw_pkg::cmd_t             push_cmd
);

  // handshake passes straight to the command queue
  assign push_valid = in_valid;
  assign in_stall   = !push_ready;

  // decode mode and character into one command
  always_comb begin
    push_cmd.ch  = char_code;
    push_cmd.idx = cell_index;
    push_cmd.op  = tmtw_pkg::OP_NOP;
    unique case (tmtw_pkg::mode_t'(mode))
      tmtw_pkg::MODE_PUT: begin
        if (char_code == tmtw_pkg::CH_NEWLINE) begin
          push_cmd.op = tmtw_pkg::OP_NEWLINE;
        end else if (char_code == tmtw_pkg::CH_BACKSPACE) begin
          push_cmd.op = tmtw_pkg::OP_BACKSPACE;
        end else begin
          push_cmd.op = tmtw_pkg::OP_PUT;
        end
      end
      tmtw_pkg::MODE_CLEAR: push_cmd.op = tmtw_pkg::OP_CLEAR;
      tmtw_pkg::MODE_READ:  push_cmd.op = tmtw_pkg::OP_READ;
      tmtw_pkg::MODE_NONE:  push_cmd.op = tmtw_pkg::OP_NOP;
      default:              push_cmd.op = tmtw_pkg::OP_NOP;
    endcase
  end

endmodule

/* src/tmtw_queue.sv */
// short command queue between front and back
module tmtw_queue #(
  parameter int DEPTH = tmtw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  tmtw_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_en,
  output tmtw_pkg::cmd_t pop_cmd
);

  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0]   PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CNTW-1:0] CNT_FULL = CNTW'(DEPTH);

  tmtw_pkg::cmd_t entries [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CNTW-1:0] count;
  logic            push;
  logic            pop;

  assign push_ready = (count != CNT_FULL);
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_en && pop_valid;
  assign pop_cmd    = entries[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CNTW'(1);
      end else if (pop && !push) begin
        count <= count - CNTW'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

/* src/tmtw_back.sv */
// back end: cursor, screen memory, fill sequencer and result register
module tmtw_back #(
  parameter int COLUMNS = tmtw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tmtw_pkg::ROWS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [tmtw_pkg::CHAR_W-1:0] cfg_wr_data,
  input  logic                        cmd_valid,
  input  tmtw_pkg::cmd_t              cmd,
  output logic                        cmd_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tmtw_pkg::POS_W-1:0]  cursor_pos,
  output logic [tmtw_pkg::CHAR_W-1:0] cell_char,
  output logic [tmtw_pkg::CHAR_W-1:0] cell_attr
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int IW    = (AW > tmtw_pkg::IDX_W) ? AW : tmtw_pkg::IDX_W;
  localparam logic [AW-1:0] LAST_BASE = AW'((ROWS - 1) * COLUMNS);
  localparam logic [AW-1:0] ROW_STEP  = AW'(COLUMNS);
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);
  localparam logic [AW:0]   CELLS_X   = (AW + 1)'(CELLS);
  localparam logic [IW-1:0] CELLS_I   = IW'(CELLS);

  // screen storage, character and attribute planes
  logic [tmtw_pkg::CHAR_W-1:0] char_mem [CELLS];
  logic [tmtw_pkg::CHAR_W-1:0] attr_mem [CELLS];
  logic [tmtw_pkg::CHAR_W-1:0] rd_char;
  logic [tmtw_pkg::CHAR_W-1:0] rd_attr;

  tmtw_pkg::back_state_t state, state_next;
  logic [tmtw_pkg::CHAR_W-1:0] text_color;
  logic [tmtw_pkg::CHAR_W-1:0] fill_color, fill_color_next;
  logic [CW-1:0]               col, col_next;
  logic [AW-1:0]               row_base, row_base_next;
  logic [AW-1:0]               top_base, top_base_next;
  logic [AW-1:0]               fill_addr, fill_addr_next;
  logic [AW-1:0]               fill_end, fill_end_next;
  logic                        rd_in_range, rd_in_range_next;

  logic                        wr_char_en;
  logic                        wr_attr_en;
  logic [AW-1:0]               wr_addr;
  logic [tmtw_pkg::CHAR_W-1:0] wr_char;
  logic [tmtw_pkg::CHAR_W-1:0] wr_attr;
  logic [AW-1:0]               rd_addr;
  logic                        load_out;
  logic [tmtw_pkg::CHAR_W-1:0] res_char;
  logic [tmtw_pkg::CHAR_W-1:0] res_attr;
  logic [AW-1:0]               lin_cur;
  logic                        out_free;

  // logical cell to physical address, rows rotate by top_base
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] lin, input logic [AW-1:0] top);
    logic [AW:0] sum;
    sum = {1'b0, lin} + {1'b0, top};
    if (sum >= CELLS_X) begin
      sum = sum - CELLS_X;
    end
    return sum[AW-1:0];
  endfunction

  assign lin_cur  = row_base + AW'(col);
  assign out_free = !out_valid || !out_stall;
  assign cmd_pop  = (state == tmtw_pkg::BK_IDLE) && cmd_valid && out_free;

  // state and cursor registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= tmtw_pkg::BK_IDLE;
      text_color  <= tmtw_pkg::COLOR_RESET;
      col         <= '0;
      row_base    <= '0;
      top_base    <= '0;
      out_valid   <= 1'b0;
    end else begin
      state    <= state_next;
      col      <= col_next;
      row_base <= row_base_next;
      top_base <= top_base_next;
      if (cfg_wr_en) begin
        text_color <= cfg_wr_data;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // fill bounds, read flag and result payload
  always_ff @(posedge clk) begin
    fill_color  <= fill_color_next;
    fill_addr   <= fill_addr_next;
    fill_end    <= fill_end_next;
    rd_in_range <= rd_in_range_next;
    if (load_out) begin
      cursor_pos <= tmtw_pkg::POS_W'(row_base_next + AW'(col_next));
      cell_char  <= res_char;
      cell_attr  <= res_attr;
    end
  end

  // screen memory, one write and one registered read per plane
  always_ff @(posedge clk) begin
    if (wr_char_en) begin
      char_mem[wr_addr] <= wr_char;
    end
    rd_char <= char_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_attr_en) begin
      attr_mem[wr_addr] <= wr_attr;
    end
    rd_attr <= attr_mem[rd_addr];
  end

  // sequencer: execute commands, walk fills, return read data
  always_comb begin
    logic row_step;
    row_step         = 1'b0;
    state_next       = state;
    col_next         = col;
    row_base_next    = row_base;
    top_base_next    = top_base;
    fill_addr_next   = fill_addr;
    fill_end_next    = fill_end;
    fill_color_next  = fill_color;
    rd_in_range_next = rd_in_range;
    wr_char_en       = 1'b0;
    wr_attr_en       = 1'b0;
    wr_addr          = fill_addr;
    wr_char          = tmtw_pkg::CH_SPACE;
    wr_attr          = fill_color;
    rd_addr          = '0;
    load_out         = 1'b0;
    res_char         = '0;
    res_attr         = '0;

    unique case (state)
      tmtw_pkg::BK_IDLE: begin
        if (cmd_pop) begin
          load_out = 1'b1;
          unique case (cmd.op)
            tmtw_pkg::OP_PUT: begin
              wr_char_en = 1'b1;
              wr_attr_en = 1'b1;
              wr_addr    = phys(lin_cur, top_base);
              wr_char    = cmd.ch;
              wr_attr    = text_color;
              if (col == COL_LAST) begin
                col_next = '0;
                row_step = 1'b1;
              end else begin
                col_next = col + CW'(1);
              end
            end
            tmtw_pkg::OP_NEWLINE: begin
              col_next = '0;
              row_step = 1'b1;
            end
            tmtw_pkg::OP_BACKSPACE: begin
              if (col != '0) begin
                col_next   = col - CW'(1);
                wr_char_en = 1'b1;
                wr_addr    = phys(lin_cur - AW'(1), top_base);
                wr_char    = tmtw_pkg::CH_SPACE;
              end
            end
            tmtw_pkg::OP_CLEAR: begin
              col_next        = '0;
              row_base_next   = '0;
              top_base_next   = '0;
              fill_addr_next  = '0;
              fill_end_next   = LAST_CELL;
              fill_color_next = text_color;
              state_next      = tmtw_pkg::BK_FILL;
            end
            tmtw_pkg::OP_READ: begin
              load_out         = 1'b0;
              rd_addr          = phys(AW'(cmd.idx), top_base);
              rd_in_range_next = (IW'(cmd.idx) < CELLS_I);
              state_next       = tmtw_pkg::BK_READ;
            end
            default: begin
            end
          endcase

          // row step, scrolling by rotating the row origin
          if (row_step) begin
            if (row_base == LAST_BASE) begin
              top_base_next   = (top_base == LAST_BASE) ? '0 : top_base + ROW_STEP;
              fill_addr_next  = top_base;
              fill_end_next   = top_base + ROW_STEP - AW'(1);
              fill_color_next = text_color;
              state_next      = tmtw_pkg::BK_FILL;
            end else begin
              row_base_next = row_base + ROW_STEP;
            end
          end
        end
      end
      tmtw_pkg::BK_FILL: begin
        wr_char_en = 1'b1;
        wr_attr_en = 1'b1;
        if (fill_addr == fill_end) begin
          state_next = tmtw_pkg::BK_IDLE;
        end else begin
          fill_addr_next = fill_addr + AW'(1);
        end
      end
      tmtw_pkg::BK_READ: begin
        load_out   = 1'b1;
        res_char   = rd_in_range ? rd_char : '0;
        res_attr   = rd_in_range ? rd_attr : '0;
        state_next = tmtw_pkg::BK_IDLE;
      end
      default: state_next = tmtw_pkg::BK_IDLE;
    endcase
  end

endmodule

/* src/text_mode_terminal_writer_unit.sv */
// top level of the text-mode terminal writer
// A text screen of ROWS x COLUMNS cells (character and attribute byte) with a
// cursor. mode 0 writes char_code at the cursor (newline and backspace are
// handled as control codes, wrap and scroll are automatic), mode 1 clears the
// screen in the current text color and homes the cursor, mode 2 returns the
// cell at cell_index; every input beat yields exactly one output beat carrying
// the linear cursor position. Beats enter a 2-deep command queue, so input
// keeps flowing while an output beat waits. The back end does one command at
// a time: a printable character, newline, backspace or unused mode is executed
// as it is popped, a read goes through a registered memory read, a line that
// scrolls writes one blank cell per cycle into the freed row (the screen rows
// rotate instead of being copied), and a clear writes one cell per cycle over the
// whole screen. The output beat of a scroll or clear is issued
// at the start of the fill. Screen memory is not cleared at reset; clear the
// screen before reading it. The text color register may be written while no
// beat is in flight and the fill has finished.
module text_mode_terminal_writer_unit #(
  parameter int COLUMNS     = tmtw_pkg::COLUMNS_DEF,
  parameter int ROWS        = tmtw_pkg::ROWS_DEF,
  parameter int QUEUE_DEPTH = tmtw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [tmtw_pkg::CHAR_W-1:0] cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [tmtw_pkg::MODE_W-1:0] mode,
  input  logic [tmtw_pkg::CHAR_W-1:0] char_code,
  input  logic [tmtw_pkg::IDX_W-1:0]  cell_index,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tmtw_pkg::POS_W-1:0]  cursor_pos,
  output logic [tmtw_pkg::CHAR_W-1:0] cell_char,
  output logic [tmtw_pkg::CHAR_W-1:0] cell_attr
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam bit POS_WRAPS = (CELLS > (1 << tmtw_pkg::POS_W));

  logic           push_valid;
  logic           push_ready;
  tmtw_pkg::cmd_t push_cmd;
  logic           q_valid;
  logic           cmd_pop;
  tmtw_pkg::cmd_t q_cmd;

  // classify incoming beats
  tmtw_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .char_code  (char_code),
    .cell_index (cell_index),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  // decouple front from back
  tmtw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (q_valid),
    .pop_en     (cmd_pop),
    .pop_cmd    (q_cmd)
  );

  // execute commands against the screen
  tmtw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd_valid   (q_valid),
    .cmd         (q_cmd),
    .cmd_pop     (cmd_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cursor_pos  (cursor_pos),
    .cell_char   (cell_char),
    .cell_attr   (cell_attr)
  );

  // a command leaves the queue only when the result slot frees up
  a_pop_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> (!out_valid || !out_stall))
    else $error("command popped while result slot is held");

  // a waiting command stays queued until the back end takes it
  a_queue_holds: assert property (@(posedge clk) disable iff (rst)
    (q_valid && !cmd_pop) |=> q_valid)
    else $error("queued command lost");

  // reported cursor stays on the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (POS_WRAPS || (32'(cursor_pos) < CELLS)))
    else $error("cursor position beyond the screen");

endmodule

/* tb/sv/tb_text_mode_terminal_writer_unit.sv */
// self-checking testbench for the text-mode terminal writer
module tb_text_mode_terminal_writer_unit;
  import tmtw_pkg::*;

  localparam int NCOL        = COLUMNS_DEF;
  localparam int NROW        = ROWS_DEF;
  localparam int CELLS       = NCOL * NROW;
  localparam int PERIOD      = 20;
  localparam int FILL_DRAIN  = CELLS + 50;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int N_SCRIPT    = 22;
  localparam int PHASE_BEATS = 330;
  localparam int N_PHASES    = 5;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [CHAR_W-1:0] ch;
    logic [CHAR_W-1:0] attr;
  } result_t;

  typedef struct {
    mode_t             m;
    logic [CHAR_W-1:0] c;
    logic [IDX_W-1:0]  ix;
    bit                typed;
    result_t           res;
  } script_row_t;

  logic              clk         = 1'b0;
  logic              rst         = 1'b1;
  logic              cfg_wr_en   = 1'b0;
  logic [CHAR_W-1:0] cfg_wr_data = '0;
  logic              in_valid    = 1'b0;
  logic              in_stall;
  logic [MODE_W-1:0] mode        = '0;
  logic [CHAR_W-1:0] char_code   = '0;
  logic [IDX_W-1:0]  cell_index  = '0;
  logic              out_valid;
  logic              out_stall   = 1'b0;
  logic [POS_W-1:0]  cursor_pos;
  logic [CHAR_W-1:0] cell_char;
  logic [CHAR_W-1:0] cell_attr;

  // shadow copy of the screen, cursor and color
  logic [CHAR_W-1:0] shadow_char [CELLS];
  logic [CHAR_W-1:0] shadow_attr [CELLS];
  int unsigned       cur_row = 0;
  int unsigned       cur_col = 0;
  logic [CHAR_W-1:0] color_q = COLOR_RESET;

  result_t     pending_results[$];
  script_row_t script [N_SCRIPT];
  int unsigned errors        = 0;
  int unsigned beats_seen    = 0;
  int unsigned cycle_count   = 0;
  int unsigned line_run_left = 0;
  bit          hold_done     = 1'b0;
  bit          sender_gaps   = 1'b1;

  text_mode_terminal_writer_unit #(
    .COLUMNS(NCOL),
    .ROWS(NROW)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .mode(mode),
    .char_code(char_code),
    .cell_index(cell_index),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cursor_pos(cursor_pos),
    .cell_char(cell_char),
    .cell_attr(cell_attr)
  );

  always #(PERIOD / 2) clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // apply one command to the shadow screen and return the result it yields
  function automatic result_t apply_command(mode_t m, logic [CHAR_W-1:0] c,
                                            logic [IDX_W-1:0] ix);
    result_t     r;
    int unsigned at;
    r = '0;
    case (m)
      MODE_PUT: begin
        if (c == CH_NEWLINE) begin
          cur_col = 0;
          cur_row++;
        end else if (c == CH_BACKSPACE) begin
          if (cur_col > 0) begin
            cur_col--;
            shadow_char[cur_row * NCOL + cur_col] = CH_SPACE;
          end
        end else begin
          at = cur_row * NCOL + cur_col;
          shadow_char[at] = c;
          shadow_attr[at] = color_q;
          cur_col++;
        end
        if (cur_col >= NCOL) begin
          cur_col = 0;
          cur_row++;
        end
        // scroll up one row and blank the bottom row
        if (cur_row >= NROW) begin
          for (int i = 0; i < (NROW - 1) * NCOL; i++) begin
            shadow_char[i] = shadow_char[i + NCOL];
            shadow_attr[i] = shadow_attr[i + NCOL];
          end
          for (int i = (NROW - 1) * NCOL; i < CELLS; i++) begin
            shadow_char[i] = CH_SPACE;
            shadow_attr[i] = color_q;
          end
          cur_row = NROW - 1;
        end
      end
      MODE_CLEAR: begin
        for (int i = 0; i < CELLS; i++) begin
          shadow_char[i] = CH_SPACE;
          shadow_attr[i] = color_q;
        end
        cur_row = 0;
        cur_col = 0;
      end
      MODE_READ: begin
        if (ix < CELLS) begin
          r.ch   = shadow_char[ix];
          r.attr = shadow_attr[ix];
        end
      end
      default: ;
    endcase
    r.pos = POS_W'(cur_row * NCOL + cur_col);
    return r;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // offer one beat, wait for it to be taken, then record what it should yield
  task automatic send_command(input mode_t m, input logic [CHAR_W-1:0] c,
                              input logic [IDX_W-1:0] ix, input bit typed,
                              input result_t typed_res);
    result_t     r;
    bit          took;
    int unsigned gap;
    gap = sender_gaps ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    mode       <= m;
    char_code  <= c;
    cell_index <= ix;
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    r = apply_command(m, c, ix);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // random command: mostly text with newlines and backspaces, some long lines
  task automatic pick_command(output mode_t m, output logic [CHAR_W-1:0] c,
                              output logic [IDX_W-1:0] ix);
    int unsigned r;
    r  = $urandom_range(0, 999);
    m  = MODE_PUT;
    c  = CHAR_W'($urandom_range(32, 126));
    ix = IDX_W'($urandom_range(0, 2047));
    if (line_run_left > 0) begin
      line_run_left--;
    end else if (r < 8) begin
      line_run_left = $urandom_range(70, 100);
    end else if (r < 10) begin
      m = MODE_CLEAR;
      c = CHAR_W'($urandom_range(0, 255));
    end else if (r < 40) begin
      m = MODE_NONE;
      c = CHAR_W'($urandom_range(0, 255));
    end else if (r < 160) begin
      m = MODE_READ;
      c = CHAR_W'($urandom_range(0, 255));
      if ($urandom_range(0, 4) == 0) ix = IDX_W'($urandom_range(CELLS, 2047));
      else ix = IDX_W'($urandom_range(0, CELLS - 1));
    end else if (r < 250) begin
      c = CH_NEWLINE;
    end else if (r < 320) begin
      c = CH_BACKSPACE;
    end else if (r < 380) begin
      c = CHAR_W'($urandom_range(0, 255));
    end
  endtask

  // result checker: beats are sampled mid-cycle, taken at the next rising edge
  always @(negedge clk) begin : result_check
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      beats_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result beat, cursor_pos %0d", cursor_pos);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (cursor_pos !== want.pos) begin
          $error("cursor_pos: expected %0d, got %0d", want.pos, cursor_pos);
          errors++;
        end
        if (cell_char !== want.ch) begin
          $error("cell_char: expected 0x%02h, got 0x%02h", want.ch, cell_char);
          errors++;
        end
        if (cell_attr !== want.attr) begin
          $error("cell_attr: expected 0x%02h, got 0x%02h", want.attr, cell_attr);
          errors++;
        end
      end
    end
  end

  // receiver: random stalls, free stretches and one long hold-off
  initial begin : receiver
    int unsigned n;
    @(posedge clk);
    forever begin
      if (!hold_done && beats_seen >= 200) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        hold_done = 1'b1;
      end
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 150) : $urandom_range(1, 6);
      out_stall <= 1'b0;
      repeat (n) @(posedge clk);
      n = idle_len();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
    end
  end

  // sender: directed script, then random phases at several text colors
  initial begin : stimulus
    mode_t             m;
    logic [CHAR_W-1:0] c;
    logic [IDX_W-1:0]  ix;
    logic [CHAR_W-1:0] color;

    // after reset, extremes, control codes, unused mode and reads out of range
    script = '{
      '{MODE_PUT,   8'h41,        11'd0,    1'b1, '{11'd1,  8'h00,    8'h00}},
      '{MODE_READ,  8'h00,        11'd0,    1'b1, '{11'd1,  8'h41,    COLOR_RESET}},
      '{MODE_CLEAR, 8'h00,        11'd0,    1'b1, '{11'd0,  8'h00,    8'h00}},
      '{MODE_READ,  8'h00,        11'd1999, 1'b1, '{11'd0,  CH_SPACE, COLOR_RESET}},
      '{MODE_READ,  8'hFF,        11'd2047, 1'b1, '{11'd0,  8'h00,    8'h00}},
      '{MODE_READ,  8'h00,        11'd2000, 1'b1, '{11'd0,  8'h00,    8'h00}},
      '{MODE_NONE,  8'hFF,        11'd2047, 1'b1, '{11'd0,  8'h00,    8'h00}},
      '{MODE_PUT,   CH_BACKSPACE, 11'd0,    1'b1, '{11'd0,  8'h00,    8'h00}},
      '{MODE_PUT,   8'hFF,        11'd0,    1'b1, '{11'd1,  8'h00,    8'h00}},
      '{MODE_PUT,   8'h00,        11'd2047, 1'b1, '{11'd2,  8'h00,    8'h00}},
      '{MODE_PUT,   CH_BACKSPACE, 11'd0,    1'b1, '{11'd1,  8'h00,    8'h00}},
      '{MODE_READ,  8'h00,        11'd1,    1'b1, '{11'd1,  CH_SPACE, COLOR_RESET}},
      '{MODE_READ,  8'h00,        11'd0,    1'b1, '{11'd1,  8'hFF,    COLOR_RESET}},
      '{MODE_PUT,   CH_NEWLINE,   11'd0,    1'b1, '{11'd80, 8'h00,    8'h00}},
      '{MODE_PUT,   CH_NEWLINE,   11'd0,    1'b0, '0},
      '{MODE_PUT,   8'h7A,        11'd0,    1'b0, '0},
      '{MODE_PUT,   CH_BACKSPACE, 11'd0,    1'b0, '0},
      '{MODE_READ,  8'h00,        11'd160,  1'b0, '0},
      '{MODE_PUT,   8'h7F,        11'd1024, 1'b0, '0},
      '{MODE_READ,  8'h00,        11'd80,   1'b0, '0},
      '{MODE_PUT,   CH_SPACE,     11'd0,    1'b0, '0},
      '{MODE_NONE,  8'h00,        11'd0,    1'b0, '0}
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i])
      send_command(script[i].m, script[i].c, script[i].ix, script[i].typed, script[i].res);

    for (int phase = 0; phase < N_PHASES; phase++) begin
      // color changes only once the screen is quiet and any fill is done
      drain();
      repeat (FILL_DRAIN) @(posedge clk);
      case (phase)
        0:       color = 8'h00;
        1:       color = 8'hFF;
        default: color = CHAR_W'($urandom_range(0, 255));
      endcase
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= color;
      @(posedge clk);
      cfg_wr_en <= 1'b0;
      color_q = color;

      sender_gaps = (phase != 3);
      for (int i = 0; i < PHASE_BEATS; i++) begin
        if (phase == 2 && i == 100) drain();
        pick_command(m, c, ix);
        send_command(m, c, ix, 1'b0, '0);
      end
    end

    drain();
    repeat (FILL_DRAIN) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
